[src/conv3x3_image_filter_assert.svh]
// Assertion macros shared by the 3x3 convolution filter modules.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef CONV3X3_IMAGE_FILTER_ASSERT_SVH
`define CONV3X3_IMAGE_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define C3X3F_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define C3X3F_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define C3X3F_ASSERT(label, expr, msg)
`define C3X3F_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

[src/c3x3f_pkg.sv]
// Package of the 3x3 convolution filter: sizes, codes, kernel table and types.
// Used by every module of the block; depends on nothing.
package c3x3f_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int LAG_W = $clog2(MAX_WIDTH + 2);

    localparam int PIX_W  = 8;
    localparam int KSEL_W = 4;
    localparam int FW_W   = 11;
    localparam int FH_W   = 13;

    // Both queues use power-of-two depths so their pointers wrap naturally.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int ODEPTH = 4;
    localparam int OPTR_W = $clog2(ODEPTH);
    localparam int OCNT_W = $clog2(ODEPTH + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_KERNEL_SELECT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd2;

    localparam logic [KSEL_W-1:0] KSEL_RESET = 4'd3;
    localparam logic [FW_W-1:0]   FW_RESET   = 11'd1024;
    localparam logic [FH_W-1:0]   FH_RESET   = 13'd4096;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [KSEL_W-1:0] KER_BLUR         = 4'd0;
    localparam logic [KSEL_W-1:0] KER_BOTTOM_SOBEL = 4'd1;
    localparam logic [KSEL_W-1:0] KER_EMBOSS       = 4'd2;
    localparam logic [KSEL_W-1:0] KER_IDENTITY     = 4'd3;
    localparam logic [KSEL_W-1:0] KER_LEFT_SOBEL   = 4'd4;
    localparam logic [KSEL_W-1:0] KER_OUTLINE      = 4'd5;
    localparam logic [KSEL_W-1:0] KER_RIGHT_SOBEL  = 4'd6;
    localparam logic [KSEL_W-1:0] KER_SHARPEN      = 4'd7;
    localparam logic [KSEL_W-1:0] KER_TOP_SOBEL    = 4'd8;

    // The blur weights 625/1250/2500 over 10000 equal 1/2/4 over 16.
    localparam int BLUR_SHIFT = 4;

    localparam int PROD_W = 14;
    localparam int SUM_W  = 16;

    typedef logic [KSEL_W-1:0] ksel_t;
    typedef logic signed [4:0] coef_t;

    localparam coef_t KERN_TAB [9][3][3] = '{
        '{'{1, 2, 1}, '{2, 4, 2}, '{1, 2, 1}},
        '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}},
        '{'{-2, -1, 0}, '{-1, 1, 1}, '{0, 1, 2}},
        '{'{0, 0, 0}, '{0, 1, 0}, '{0, 0, 0}},
        '{'{1, 0, -1}, '{2, 0, -2}, '{1, 0, -1}},
        '{'{-1, -1, -1}, '{-1, 8, -1}, '{-1, -1, -1}},
        '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}},
        '{'{0, -1, 0}, '{-1, 5, -1}, '{0, -1, 0}},
        '{'{1, 2, 1}, '{0, 0, 0}, '{-1, -2, -1}}
    };

    // Kernel numbers past the table select an all-zero kernel.
    function automatic coef_t kernel_coef(input ksel_t ksel, input int r, input int k);
        coef_t c;
        c = '0;
        if (ksel <= KER_TOP_SOBEL)
        begin
            c = KERN_TAB[int'(ksel)][r][k];
        end
        return c;
    endfunction

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } out_item_t;

    typedef struct packed {
        logic             shift;
        logic             emit;
        logic             interior;
        logic             last;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] px;
    } cmd_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              nonempty;
    } qstat_t;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
    } geom_t;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } line_word_t;

endpackage

[src/c3x3f_queue.sv]
// Short command queue between the front and back parts of the filter.
// Depends on c3x3f_pkg for the command type and the depth.
`include "conv3x3_image_filter_assert.svh"

module c3x3f_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  c3x3f_pkg::cmd_t   din,
    input  logic              pop,
    output c3x3f_pkg::cmd_t   dout,
    output c3x3f_pkg::qstat_t stat
);
    import c3x3f_pkg::*;

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_pop;

    assign do_pop        = pop && (cnt_reg != '0);
    assign dout          = mem[rptr_reg];
    assign stat.count    = cnt_reg;
    assign stat.nonempty = (cnt_reg != '0);

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = wptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = rptr_reg + QPTR_W'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= din;
        end
    end

    `C3X3F_ASSERT(a_queue_no_overflow, !(push && !do_pop && (32'(cnt_reg) == QDEPTH)), "command queue overflow")

endmodule

[src/c3x3f_front.sv]
// Front part of the filter: takes transactions, tracks raster positions,
// owns the line store and queues one command per useful item. Uses c3x3f_pkg.
`include "conv3x3_image_filter_assert.svh"

module c3x3f_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  c3x3f_pkg::geom_t    geom,
    input  logic                push,
    input  c3x3f_pkg::in_item_t in_data,
    output logic                full,
    input  c3x3f_pkg::qstat_t   qstat,
    output logic                q_push,
    output c3x3f_pkg::cmd_t     q_entry
);
    import c3x3f_pkg::*;

    // Each word holds the two newest pixels of its column: the two rows above the next pixel there.
    line_word_t       line_mem [MAX_WIDTH];
    line_word_t       rd_reg;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             done_reg, done_next;
    logic [LAG_W-1:0] lag_reg, lag_next;

    logic             s1_valid_reg, s1_valid_next;
    cmd_t             s1_cmd_reg, s1_cmd_next;
    logic [COL_W-1:0] s1_addr_reg;

    logic             accept;
    logic             take_pixel;
    logic             take_drain;
    logic             do_emit;
    logic             interior;
    logic             last;

    // Room is reserved for the command still waiting on the line store read.
    assign full       = (32'(qstat.count) + 32'(s1_valid_reg)) >= QDEPTH;
    assign accept     = push && !full;
    assign take_pixel = accept && (in_data.opcode == OP_PIXEL) && !done_reg;
    assign take_drain = accept && (in_data.opcode == OP_DRAIN) && done_reg;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        done_next    = done_reg;
        lag_next     = lag_reg;
        do_emit      = 1'b0;

        interior = (out_row_reg != '0) && ((32'(out_row_reg) + 2) <= 32'(geom.height)) &&
                   (out_col_reg != '0) && ((32'(out_col_reg) + 2) <= 32'(geom.width));
        last     = ((32'(out_row_reg) + 1) == 32'(geom.height)) &&
                   ((32'(out_col_reg) + 1) == 32'(geom.width));

        if (take_pixel)
        begin
            if ((32'(in_col_reg) + 1) >= 32'(geom.width))
            begin
                in_col_next = '0;
                if ((32'(in_row_reg) + 1) >= 32'(geom.height))
                begin
                    in_row_next = '0;
                    done_next   = 1'b1;
                end
                else
                begin
                    in_row_next = in_row_reg + ROW_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            // Once a full row plus one pixel is pending, every pixel pushes one out.
            if (32'(lag_reg) >= (32'(geom.width) + 1))
            begin
                do_emit = 1'b1;
            end
            else
            begin
                lag_next = lag_reg + LAG_W'(1);
            end
        end

        if (take_drain)
        begin
            do_emit  = 1'b1;
            lag_next = lag_reg - LAG_W'(1);
        end

        if (do_emit)
        begin
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                done_next    = 1'b0;
                lag_next     = '0;
            end
            else if ((32'(out_col_reg) + 1) >= 32'(geom.width))
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            done_next    = 1'b0;
            lag_next     = '0;
        end

        s1_valid_next        = take_pixel || take_drain;
        s1_cmd_next.shift    = take_pixel;
        s1_cmd_next.emit     = do_emit;
        s1_cmd_next.interior = interior;
        s1_cmd_next.last     = last;
        s1_cmd_next.top      = '0;
        s1_cmd_next.mid      = '0;
        s1_cmd_next.px       = in_data.pixel_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            done_reg     <= 1'b0;
            lag_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            done_reg     <= done_next;
            lag_reg      <= lag_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg  <= s1_cmd_next;
        s1_addr_reg <= in_col_reg;
    end

    // Read when a pixel is taken, write the shifted column back in the next cycle.
    // Consecutive pixels never share a column, so the two never collide.
    always_ff @(posedge clk)
    begin
        if (take_pixel)
        begin
            rd_reg <= line_mem[in_col_reg];
        end
        if (s1_valid_reg && s1_cmd_reg.shift)
        begin
            line_mem[s1_addr_reg] <= '{upper: rd_reg.middle, middle: s1_cmd_reg.px};
        end
    end

    always_comb
    begin
        q_push       = s1_valid_reg;
        q_entry      = s1_cmd_reg;
        q_entry.top  = rd_reg.upper;
        q_entry.mid  = rd_reg.middle;
    end

    `C3X3F_ASSERT(a_lag_bound, 32'(lag_reg) <= (32'(geom.width) + 1), "pending result count too large")
    `C3X3F_ASSERT_IMPL(a_done_at_origin, done_reg, (in_col_reg == '0) && (in_row_reg == '0), "input position not reset at frame end")

endmodule

[src/c3x3f_back.sv]
// Back part of the filter: shifts the 3x3 window, applies the kernel in two
// stages and buffers results for the output side. Uses c3x3f_pkg.
`include "conv3x3_image_filter_assert.svh"

module c3x3f_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 restart,
    input  c3x3f_pkg::ksel_t     kernel_sel,
    input  c3x3f_pkg::cmd_t      q_head,
    input  c3x3f_pkg::qstat_t    qstat,
    output logic                 q_pop,
    output c3x3f_pkg::out_item_t out_data,
    output logic                 empty,
    input  logic                 pop
);
    import c3x3f_pkg::*;

    logic [PIX_W-1:0]        win_reg [3][3];
    logic [PIX_W-1:0]        win_next [3][3];

    logic                    p1_valid_reg;
    logic                    p1_interior_reg;
    logic                    p1_last_reg;
    logic                    p2_valid_reg;
    logic                    p2_interior_reg;
    logic                    p2_last_reg;
    logic signed [SUM_W-1:0] p2_row_reg [3];
    logic signed [SUM_W-1:0] row_sum [3];
    logic signed [SUM_W-1:0] total;
    logic [PIX_W-1:0]        result_pix;

    out_item_t               out_mem [ODEPTH];
    logic [OPTR_W-1:0]       out_wptr_reg, out_wptr_next;
    logic [OPTR_W-1:0]       out_rptr_reg, out_rptr_next;
    logic [OCNT_W-1:0]       out_cnt_reg, out_cnt_next;
    logic                    out_rd;
    logic                    credit_ok;

    // A command that yields a result is taken only when the output buffer has a
    // slot for it, so the two arithmetic stages never stall.
    assign credit_ok = (32'(out_cnt_reg) + 32'(p1_valid_reg) + 32'(p2_valid_reg)) < ODEPTH;
    assign q_pop     = qstat.nonempty && (!q_head.emit || credit_ok);

    always_comb
    begin
        win_next = win_reg;
        if (q_pop && q_head.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = q_head.top;
            win_next[1][2] = q_head.mid;
            win_next[2][2] = q_head.px;
        end
        if (restart)
        begin
            win_next = '{default: '0};
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = '0;
            for (int k = 0; k < 3; k++)
            begin
                row_sum[r] = row_sum[r] +
                    SUM_W'(PROD_W'(kernel_coef(kernel_sel, r, k)) *
                           PROD_W'($signed({1'b0, win_reg[r][k]})));
            end
        end
    end

    always_comb
    begin
        total = p2_row_reg[0] + p2_row_reg[1] + p2_row_reg[2];
        if (kernel_sel == KER_BLUR)
        begin
            total = total >>> BLUR_SHIFT;
        end
        if (!p2_interior_reg || (total < 0))
        begin
            result_pix = '0;
        end
        else if (total > 255)
        begin
            result_pix = 8'd255;
        end
        else
        begin
            result_pix = total[PIX_W-1:0];
        end
    end

    assign out_rd   = pop && (out_cnt_reg != '0);
    assign empty    = (out_cnt_reg == '0);
    assign out_data = out_mem[out_rptr_reg];

    always_comb
    begin
        out_wptr_next = out_wptr_reg;
        out_rptr_next = out_rptr_reg;
        out_cnt_next  = out_cnt_reg;
        if (p2_valid_reg)
        begin
            out_wptr_next = out_wptr_reg + OPTR_W'(1);
        end
        if (out_rd)
        begin
            out_rptr_next = out_rptr_reg + OPTR_W'(1);
        end
        if (p2_valid_reg && !out_rd)
        begin
            out_cnt_next = out_cnt_reg + OCNT_W'(1);
        end
        else if (!p2_valid_reg && out_rd)
        begin
            out_cnt_next = out_cnt_reg - OCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '{default: '0};
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            out_wptr_reg <= '0;
            out_rptr_reg <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            win_reg      <= win_next;
            p1_valid_reg <= q_pop && q_head.emit;
            p2_valid_reg <= p1_valid_reg;
            out_wptr_reg <= out_wptr_next;
            out_rptr_reg <= out_rptr_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_interior_reg <= q_head.interior;
        p1_last_reg     <= q_head.last;
        p2_interior_reg <= p1_interior_reg;
        p2_last_reg     <= p1_last_reg;
        p2_row_reg      <= row_sum;
        if (p2_valid_reg)
        begin
            out_mem[out_wptr_reg] <= '{pixel_out: result_pix, frame_last: p2_last_reg};
        end
    end

    `C3X3F_ASSERT(a_out_credit, (32'(out_cnt_reg) + 32'(p1_valid_reg) + 32'(p2_valid_reg)) <= ODEPTH, "output buffer credit exceeded")
    `C3X3F_ASSERT_IMPL(a_last_on_border, p2_valid_reg && p2_last_reg, !p2_interior_reg, "frame end result inside the image")

endmodule

[src/conv3x3_image_filter.sv]
// Top level of the 3x3 convolution filter: configuration registers, APB port
// and the front, queue and back parts. Uses c3x3f_pkg.
//
// The filter takes one transaction per clock on the input queue interface and
// returns one result per clock on the output side, as long as the output side
// keeps popping. The input reports full only when the command queue backs up,
// which happens when results are not popped. A pixel item is read from the line
// store at the edge that takes it and its column is written back in the next
// cycle; the command queue then feeds the window and two arithmetic stages, and
// the second stage writes each result into the output buffer.
// Results trail the pixels by
// one row plus one pixel: after the last pixel of a frame, frame_width + 1
// drain items flush the rest, and the final one carries frame_last. Pixel items
// after the frame is complete and drain items before it are taken and dropped.
// Any write to kernel_select, frame_width or frame_height restarts the frame;
// write only while no results are outstanding. Sizes outside 3..1024 columns
// and 3..4096 rows are saturated. The line store needs no clearing pass.
module conv3x3_image_filter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  c3x3f_pkg::in_item_t                    in_data,
    output logic                                   full,
    input  logic                                   pop,
    output c3x3f_pkg::out_item_t                   out_data,
    output logic                                   empty,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [c3x3f_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [c3x3f_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [c3x3f_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                   pready
);
    import c3x3f_pkg::*;

    logic [KSEL_W-1:0]    kernel_reg, kernel_next;
    logic [FW_W-1:0]      fwidth_reg, fwidth_next;
    logic [FH_W-1:0]      fheight_reg, fheight_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic                 restart;
    geom_t                geom;
    cmd_t                 q_entry;
    cmd_t                 q_head;
    qstat_t               qstat;
    logic                 q_push;
    logic                 q_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        kernel_next  = kernel_reg;
        fwidth_next  = fwidth_reg;
        fheight_next = fheight_reg;
        restart      = 1'b0;
        if (wr_en)
        begin
            case (reg_idx)
                REG_KERNEL_SELECT:
                begin
                    kernel_next = pwdata[KSEL_W-1:0];
                    restart     = 1'b1;
                end
                REG_FRAME_WIDTH:
                begin
                    fwidth_next = pwdata[FW_W-1:0];
                    restart     = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    fheight_next = pwdata[FH_W-1:0];
                    restart      = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg  <= KSEL_RESET;
            fwidth_reg  <= FW_RESET;
            fheight_reg <= FH_RESET;
        end
        else
        begin
            kernel_reg  <= kernel_next;
            fwidth_reg  <= fwidth_next;
            fheight_reg <= fheight_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KERNEL_SELECT: prdata = APB_DATA_W'(kernel_reg);
            REG_FRAME_WIDTH:   prdata = APB_DATA_W'(fwidth_reg);
            REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(fheight_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        if (fwidth_reg < FW_W'(3))
        begin
            geom.width = WID_W'(3);
        end
        else if (32'(fwidth_reg) > MAX_WIDTH)
        begin
            geom.width = WID_W'(MAX_WIDTH);
        end
        else
        begin
            geom.width = WID_W'(fwidth_reg);
        end
        if (fheight_reg < FH_W'(3))
        begin
            geom.height = HGT_W'(3);
        end
        else if (32'(fheight_reg) > MAX_HEIGHT)
        begin
            geom.height = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            geom.height = HGT_W'(fheight_reg);
        end
    end

    c3x3f_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .geom    (geom),
        .push    (push),
        .in_data (in_data),
        .full    (full),
        .qstat   (qstat),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    c3x3f_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_entry),
        .pop   (q_pop),
        .dout  (q_head),
        .stat  (qstat)
    );

    c3x3f_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .kernel_sel (kernel_reg),
        .q_head     (q_head),
        .qstat      (qstat),
        .q_pop      (q_pop),
        .out_data   (out_data),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

[test/conv3x3_image_filter_tb.sv]
`timescale 1ns / 1ps
// Testbench of conv3x3_image_filter: random frames go through the pixel queue while a
// scoreboard convolves the same stream and checks every result transaction.
// Depends on c3x3f_pkg and the filter RTL only.
module conv3x3_image_filter_tb;
    import c3x3f_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int STREAM_ITEMS  = 750;
    localparam int QUIET_AFTER   = 600;
    localparam int MAX_REPORTS   = 100;

    localparam ksel_t KER_UNDEFINED_TOP = 4'hF;

    // Blur keeps its full-scale weights; the sum is divided by 10000 afterwards.
    localparam int KERNEL_WEIGHTS [9][3][3] = '{
        '{'{625, 1250, 625}, '{1250, 2500, 1250}, '{625, 1250, 625}},
        '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}},
        '{'{-2, -1, 0}, '{-1, 1, 1}, '{0, 1, 2}},
        '{'{0, 0, 0}, '{0, 1, 0}, '{0, 0, 0}},
        '{'{1, 0, -1}, '{2, 0, -2}, '{1, 0, -1}},
        '{'{-1, -1, -1}, '{-1, 8, -1}, '{-1, -1, -1}},
        '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}},
        '{'{0, -1, 0}, '{-1, 5, -1}, '{0, -1, 0}},
        '{'{1, 2, 1}, '{0, 0, 0}, '{-1, -2, -1}}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    in_item_t              in_data;
    logic                  full;
    logic                  pop;
    out_item_t             out_data;
    logic                  empty;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit          idle_on;
    bit          hold_req;
    int unsigned stream_items;

    class filter_scoreboard;
        ksel_t            kernel;
        logic [FW_W-1:0]  width_reg;
        logic [FH_W-1:0]  height_reg;
        logic [PIX_W-1:0] upper_row [MAX_WIDTH];
        logic [PIX_W-1:0] middle_row [MAX_WIDTH];
        logic [PIX_W-1:0] win [3][3];
        int unsigned      in_col;
        int unsigned      in_row;
        int unsigned      out_col;
        int unsigned      out_row;
        bit               in_done;
        out_item_t        pending_pixels [$];
        int               errors;

        function new();
            kernel     = KSEL_RESET;
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (win[r, k])
            begin
                win[r][k] = '0;
            end
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            in_done = 1'b0;
        endfunction

        function int unsigned width_eff();
            if (width_reg < 3)
                return 3;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned height_eff();
            if (height_reg < 3)
                return 3;
            if (height_reg > MAX_HEIGHT)
                return MAX_HEIGHT;
            return height_reg;
        endfunction

        // Every register write restarts the frame; the line rows are kept.
        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_KERNEL_SELECT: kernel     = value[KSEL_W-1:0];
                REG_FRAME_WIDTH:   width_reg  = value[FW_W-1:0];
                REG_FRAME_HEIGHT:  height_reg = value[FH_W-1:0];
                default:           return;
            endcase
            restart();
        endfunction

        function logic [PIX_W-1:0] convolve_window();
            int sum;
            int r;
            int k;
            sum = 0;
            if (kernel > KER_TOP_SOBEL)
                return '0;
            for (r = 0; r < 3; r++)
            begin
                for (k = 0; k < 3; k++)
                begin
                    sum += KERNEL_WEIGHTS[kernel][r][k] * int'(win[r][k]);
                end
            end
            if (kernel == KER_BLUR)
                sum = sum / 10000;
            if (sum < 0)
                sum = 0;
            if (sum > 255)
                sum = 255;
            return sum[PIX_W-1:0];
        endfunction

        function void emit_pixel(int unsigned w, int unsigned h);
            out_item_t res;
            res.pixel_out = '0;
            if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w)
                res.pixel_out = convolve_window();
            res.frame_last = (out_row == h - 1) && (out_col == w - 1);
            pending_pixels.push_back(res);
            // The window is not cleared at frame end, only the counters.
            if (res.frame_last)
            begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
                in_done = 1'b0;
            end
            else
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void note_item(in_item_t item);
            int unsigned      w;
            int unsigned      h;
            int unsigned      taken;
            int unsigned      sent;
            int               r;
            logic [PIX_W-1:0] top;
            logic [PIX_W-1:0] mid;
            w = width_eff();
            h = height_eff();
            if (item.opcode == OP_DRAIN)
            begin
                if (in_done)
                    emit_pixel(w, h);
                return;
            end
            if (in_done)
                return;
            top = upper_row[in_col];
            mid = middle_row[in_col];
            upper_row[in_col]  = mid;
            middle_row[in_col] = item.pixel_in;
            for (r = 0; r < 3; r++)
            begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = item.pixel_in;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                begin
                    in_row  = 0;
                    in_done = 1'b1;
                end
            end
            taken = in_done ? h * w : in_row * w + in_col;
            sent  = out_row * w + out_col;
            if (taken - sent > w + 1)
                emit_pixel(w, h);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_pixel(out_item_t got);
            out_item_t want;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: pixel_out=%0d frame_last=%0b",
                                          got.pixel_out, got.frame_last));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.pixel_out !== want.pixel_out)
                report_mismatch($sformatf("pixel_out %0d, predicted %0d",
                                          got.pixel_out, want.pixel_out));
            if (got.frame_last !== want.frame_last)
                report_mismatch($sformatf("frame_last %0b, predicted %0b",
                                          got.frame_last, want.frame_last));
        endtask

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    filter_scoreboard sb;

    conv3x3_image_filter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_data  (in_data),
        .full     (full),
        .pop      (pop),
        .out_data (out_data),
        .empty    (empty),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_item(in_data);
            if (pop && !empty)
                sb.check_pixel(out_data);
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one transaction and returns at the edge where it is taken.
    task automatic push_item(logic op, logic [PIX_W-1:0] value);
        in_item_t item;
        int       gap;
        item.opcode   = op;
        item.pixel_in = value;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push    <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(ksel_t ks, logic [FW_W-1:0] fw, logic [FH_W-1:0] fh);
        write_reg(REG_KERNEL_SELECT, APB_DATA_W'(ks));
        write_reg(REG_FRAME_WIDTH, APB_DATA_W'(fw));
        write_reg(REG_FRAME_HEIGHT, APB_DATA_W'(fh));
    endtask

    // Items that give no result may still be in flight, so allow a few more cycles.
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_frame(int unsigned npix, int unsigned ndrain, bit noisy, bit counted);
        int unsigned i;
        for (i = 0; i < npix; i++)
        begin
            if (noisy && $urandom_range(0, 39) == 0)
                push_item(OP_DRAIN, random_pixel());
            push_item(OP_PIXEL, random_pixel());
            if (counted)
                stream_items++;
        end
        if (noisy && $urandom_range(0, 1) == 0)
            push_item(OP_PIXEL, random_pixel());
        for (i = 0; i < ndrain; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                push_item(OP_PIXEL, random_pixel());
            push_item(OP_DRAIN, random_pixel());
            if (counted)
                stream_items++;
        end
    endtask

    initial
    begin
        int               i;
        int unsigned      frame_idx;
        int unsigned      w;
        int unsigned      h;
        ksel_t            ks;
        logic [FW_W-1:0]  fw;
        logic [FH_W-1:0]  fh;
        sb           = new();
        rst_n        = 1'b0;
        push         = 1'b0;
        in_data      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        stream_items = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sizes below range saturate to a 3x3 frame. Around it: a drain before the
        // frame is complete, and a pixel after it, both of which are dropped.
        configure(KER_OUTLINE, 11'd0, 13'd1);
        push_item(OP_DRAIN, 8'hFF);
        for (i = 0; i < 9; i++)
        begin
            push_item(OP_PIXEL, (i % 2 == 0) ? 8'hFF : 8'h00);
        end
        push_item(OP_PIXEL, 8'h55);
        repeat (4) push_item(OP_DRAIN, 8'h00);
        push_item(OP_DRAIN, 8'hFF);
        wait_idle();

        // An undefined kernel number filters everything to zero.
        configure(KER_UNDEFINED_TOP, 11'd3, 13'd3);
        repeat (9) push_item(OP_PIXEL, 8'hFF);
        repeat (4) push_item(OP_DRAIN, 8'h00);
        wait_idle();

        frame_idx = 0;
        while (stream_items < STREAM_ITEMS)
        begin
            if (frame_idx <= KER_TOP_SOBEL)
                ks = ksel_t'(frame_idx);
            else if ($urandom_range(0, 7) == 0)
                ks = ksel_t'($urandom_range(9, 15));
            else
                ks = ksel_t'($urandom_range(0, 8));
            fw = ($urandom_range(0, 7) == 0) ? FW_W'($urandom_range(0, 2))
                                             : FW_W'($urandom_range(3, 9));
            fh = ($urandom_range(0, 7) == 0) ? FH_W'($urandom_range(0, 2))
                                             : FH_W'($urandom_range(3, 9));
            case (frame_idx)
                1:
                begin
                    fw = 11'd8;
                    fh = 13'd8;
                end
                2:
                begin
                    fw = 11'd1024;
                    fh = 13'd3;
                end
                4:
                begin
                    fw = 11'h7FF;
                    fh = 13'h1FFF;
                end
                6:
                begin
                    fw = 11'd3;
                    fh = 13'd4096;
                end
                default:
                begin
                end
            endcase
            configure(ks, fw, fh);
            w = sb.width_eff();
            h = sb.height_eff();
            // The result side holds off while the frame streams in, so the block fills up.
            if (frame_idx == 1)
                hold_req = 1'b1;
            if (frame_idx == 2)
                run_frame(80, 0, 1'b0, 1'b1);
            else if (frame_idx == 4)
                run_frame(80, 0, 1'b0, 1'b1);
            else if (frame_idx == 6)
                run_frame(150, 0, 1'b0, 1'b1);
            else if ($urandom_range(0, 9) == 0)
                run_frame($urandom_range(1, w * h), 0, 1'b1, 1'b1);
            else if ($urandom_range(0, 9) == 0)
                run_frame(w * h, $urandom_range(0, w), 1'b1, 1'b1);
            else
                run_frame(w * h, w + 1, 1'b1, 1'b1);
            wait_idle();
            frame_idx++;
            if (stream_items > QUIET_AFTER)
                idle_on = 1'b0;
        end

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/c3x3f_pkg.sv
src/c3x3f_queue.sv
src/c3x3f_front.sv
src/c3x3f_back.sv
src/conv3x3_image_filter.sv
test/conv3x3_image_filter_tb.sv
